/* sv/rmv_pkg.sv */
// Shared widths, constants and sequencer state type for the running mean/variance core.
`default_nettype none
package rmv_pkg;
    localparam int SampleWidth = 16;
    localparam int CountWidth  = 32;
    localparam int MeanWidth   = 48;
    localparam int M2Width     = 64;
    localparam int VarWidth    = 48;
    localparam int SdWidth     = 32;
    localparam int AluWidth    = 64;
    localparam int StepWidth   = 6;

    localparam logic [StepWidth-1:0] DivLast  = 6'd63;
    localparam logic [StepWidth-1:0] MulLast  = 6'd47;
    localparam logic [StepWidth-1:0] SqrtLast = 6'd31;

    localparam logic [AluWidth-1:0] SqrtInit = 64'h4000_0000_0000_0000;

    localparam logic FuncAdd   = 1'b0;
    localparam logic FuncClear = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIVM = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIVV = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;
endpackage
`default_nettype wire

/* sv/running_mean_variance_core.sv */
// Welford running mean / variance / std deviation core with a shared serial add/sub unit.
//
//  channel | dir | beat contents
//  s_      | in  | tdata: sample ; tuser: func
//  m_      | out | tdata: count, mean, variance, std_dev ; tuser: overflow
//
//  Add beat: mean divide, multiply, variance divide, sqrt, then a load of the output
//  register. No new sample is accepted until the sequencer is back in ST_IDLE.
//  Below two samples the variance divide is skipped; clear runs only the sqrt;
//  an add on a full count skips the mean divide and multiply.
//  Synchronous active-low reset; the result is registered, so the next beat is taken while
//  it waits, but the load stalls in ST_OUT until the previous result is taken.
`default_nettype none
module running_mean_variance_core
    import rmv_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [15:0] sample
    input  wire logic         s_tuser,   // [0] func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,   // [31:0] sample_count, [63:32] mean,
                                         // [111:64] variance, [143:112] std_dev
    output logic              m_tuser    // [0] overflow
);
    state_t state_reg, state_next;
    logic [StepWidth-1:0]  step_reg, step_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [MeanWidth-1:0]  mean_reg, mean_next;
    logic [M2Width-1:0]    m2_reg, m2_next;
    logic                  sat_reg, sat_next;
    logic [VarWidth-1:0]   var_reg, var_next;
    logic                  neg_reg, neg_next;
    logic [AluWidth-1:0]   acc_reg, acc_next;
    logic [AluWidth-1:0]   wrk_reg, wrk_next;
    logic [AluWidth-1:0]   opb_reg, opb_next;
    logic [AluWidth-1:0]   bit_reg, bit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [143:0]          out_data_reg, out_data_next;
    logic                  out_user_reg, out_user_next;
    logic                  out_load;

    logic [AluWidth-1:0] alu_a, alu_b;
    logic                alu_sub;
    logic [AluWidth:0]   alu_sum;
    logic                alu_c;

    logic [MeanWidth:0]   xs, delta;
    logic [MeanWidth-1:0] dmag, quo;
    logic [AluWidth-1:0]  div_q;
    logic [M2Width:0]     m2_sum;
    logic [32:0]          div_t;

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{AluWidth{1'b0}}, alu_sub};
    assign alu_c   = alu_sum[AluWidth];

    assign div_t = {acc_reg[31:0], wrk_reg[AluWidth-1]};
    assign div_q = {wrk_reg[AluWidth-2:0], alu_c};
    assign quo   = div_q[MeanWidth-1:0];

    assign m2_sum = {1'b0, m2_reg} + {17'b0, alu_sum[MeanWidth:1]};

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_DIVM, ST_DIVV: begin
                alu_a   = {31'b0, div_t};
                alu_b   = opb_reg;
                alu_sub = 1'b1;
            end
            ST_MUL: begin
                alu_a = acc_reg;
                alu_b = wrk_reg[0] ? opb_reg : '0;
            end
            ST_SQRT: begin
                alu_a   = acc_reg;
                alu_b   = wrk_reg | bit_reg;
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        xs    = {s_tdata[SampleWidth-1], s_tdata, 32'b0};
        delta = xs - {mean_reg[MeanWidth-1], mean_reg};
        dmag  = delta[MeanWidth] ? 48'(-delta) : delta[MeanWidth-1:0];
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg + 1'b1;
        count_next = count_reg;
        mean_next  = mean_reg;
        m2_next    = m2_reg;
        sat_next   = sat_reg;
        var_next   = var_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        wrk_next   = wrk_reg;
        opb_next   = opb_reg;
        bit_next   = bit_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    if (s_tuser == FuncClear) begin
                        count_next = '0;
                        mean_next  = '0;
                        m2_next    = '0;
                        sat_next   = 1'b0;
                        var_next   = '0;
                        acc_next   = '0;
                        wrk_next   = '0;
                        bit_next   = SqrtInit;
                        state_next = ST_SQRT;
                    end else if (count_reg == '1) begin
                        sat_next   = 1'b1;
                        state_next = ST_DIVV;
                        acc_next   = '0;
                        wrk_next   = m2_reg;
                        opb_next   = {32'b0, count_reg - 1'b1};
                    end else begin
                        count_next = count_reg + 1'b1;
                        neg_next   = delta[MeanWidth];
                        acc_next   = '0;
                        wrk_next   = {16'b0, dmag};
                        opb_next   = {32'b0, count_reg + 1'b1};
                        bit_next   = {16'b0, dmag};
                        state_next = ST_DIVM;
                    end
                end
            end
            ST_DIVM, ST_DIVV: begin
                acc_next = alu_c ? {32'b0, alu_sum[31:0]} : {32'b0, div_t[31:0]};
                wrk_next = div_q;
                if (step_reg == DivLast) begin
                    step_next = '0;
                    if (state_reg == ST_DIVM) begin
                        // |x - new mean| = |delta| - quotient
                        mean_next  = neg_reg ? mean_reg - quo : mean_reg + quo;
                        acc_next   = '0;
                        opb_next   = bit_reg;
                        wrk_next   = {16'b0, bit_reg[MeanWidth-1:0] - quo};
                        state_next = ST_MUL;
                    end else begin
                        var_next   = (div_q[AluWidth-1:VarWidth] != '0) ? '1
                                                                       : div_q[VarWidth-1:0];
                        acc_next   = {var_next, 16'b0};
                        wrk_next   = '0;
                        bit_next   = SqrtInit;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_MUL: begin
                acc_next = {1'b0, alu_sum[AluWidth-1:1]};
                wrk_next = {16'b0, alu_sum[0], wrk_reg[MeanWidth-1:1]};
                if (step_reg == MulLast) begin
                    step_next = '0;
                    if (m2_sum[M2Width]) begin
                        m2_next  = '1;
                        sat_next = 1'b1;
                    end else begin
                        m2_next = m2_sum[M2Width-1:0];
                    end
                    if (count_reg >= 32'd2) begin
                        state_next = ST_DIVV;
                        acc_next   = '0;
                        wrk_next   = m2_next;
                        opb_next   = {32'b0, count_reg - 1'b1};
                    end else begin
                        state_next = ST_SQRT;
                        var_next   = '0;
                        acc_next   = '0;
                        wrk_next   = '0;
                        bit_next   = SqrtInit;
                    end
                end
            end
            ST_SQRT: begin
                if (alu_c) begin
                    acc_next = alu_sum[AluWidth-1:0];
                    wrk_next = (wrk_reg >> 1) | bit_reg;
                end else begin
                    wrk_next = wrk_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (step_reg == SqrtLast) begin
                    step_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                step_next = '0;
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_load       = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {wrk_reg[SdWidth-1:0], var_reg, mean_reg[MeanWidth-1:16],
                              count_reg};
            out_user_next  = sat_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            sat_reg       <= 1'b0;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            m2_reg        <= m2_next;
            sat_reg       <= sat_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        wrk_reg      <= wrk_next;
        opb_reg      <= opb_next;
        bit_reg      <= bit_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FuncClear |=> count_reg == '0 && !sat_reg)
        else $error("clear did not zero state");
    a_var_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:0] < 32'd2 |-> m_tdata[111:64] == '0)
        else $error("variance nonzero below two samples");
    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> step_reg == '0)
        else $error("step counter not parked");
endmodule
`default_nettype wire
